// ===== hw/rtl/integer_alu_with_carry_top_defines.svh =====
// Assertion helpers for the integer ALU.
`ifndef INTEGER_ALU_WITH_CARRY_TOP_DEFINES_SVH
`define INTEGER_ALU_WITH_CARRY_TOP_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define IAWC_ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("iawc assertion failed");
// next-cycle implication
`define IAWC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("iawc assertion failed");
`else
`define IAWC_ASSERT_IMPLY(lbl, ck, rn, ante, cons)
`define IAWC_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif

`endif

// ===== hw/rtl/iawc_pkg.sv =====
package iawc_pkg;

    localparam int WordW    = 32;
    localparam int HalfW    = 16;
    localparam int PartW    = WordW + HalfW + 2;   // 33x17 signed partial product
    localparam int ShiftW   = 5;
    localparam int KindW    = 5;
    localparam int InDataW  = 72;
    localparam int OutDataW = 40;

    typedef enum logic [KindW-1:0] {
        OP_ADD    = 5'd0,
        OP_ADDC   = 5'd1,
        OP_RSUB   = 5'd2,
        OP_RSUBC  = 5'd3,
        OP_CMP    = 5'd4,
        OP_CMPU   = 5'd5,
        OP_MUL    = 5'd6,
        OP_MULH   = 5'd7,
        OP_MULHU  = 5'd8,
        OP_MULHSU = 5'd9,
        OP_OR     = 5'd10,
        OP_AND    = 5'd11,
        OP_XOR    = 5'd12,
        OP_ANDN   = 5'd13,
        OP_BSLL   = 5'd14,
        OP_BSRA   = 5'd15,
        OP_BSRL   = 5'd16,
        OP_SRA    = 5'd17,
        OP_SRC    = 5'd18,
        OP_SRL    = 5'd19,
        OP_SEXT   = 5'd20,
        OP_EQ     = 5'd21,
        OP_NE     = 5'd22,
        OP_LT     = 5'd23,
        OP_LE     = 5'd24,
        OP_GT     = 5'd25,
        OP_GE     = 5'd26
    } alu_op_t;

    // which word stage 3 hands out
    typedef enum logic [1:0] {
        SEL_MISC   = 2'd0,
        SEL_MUL_LO = 2'd1,
        SEL_MUL_HI = 2'd2
    } res_sel_t;

    typedef struct packed {
        logic [KindW-1:0] kind;
        logic [WordW-1:0] a;
        logic [WordW-1:0] b;
        logic             cin;
        logic             a_sx;   // sign extension bit of a for the multiplier
        logic             b_sx;
    } s1_pay_t;

    typedef struct packed {
        res_sel_t           sel;
        logic [WordW-1:0]   misc_res;
        logic               misc_cy;
        logic [PartW-1:0]   pp_lo;    // a times low half of b
        logic [PartW-1:0]   pp_hi;    // a times high half of b
    } s2_pay_t;

endpackage

// ===== hw/rtl/integer_alu_with_carry_top.sv =====
// Channel  | Ports            | Contents (low bit up)
// ---------+------------------+---------------------------------------------------
// in       | s_axis_t*        | tdata: operand_a, operand_b, carry_in, 7 zero bits
//          |                  | tuser: kind
// out      | m_axis_t*        | tdata: result, carry_out, negative, zero, 5 zero bits
//
// Three register stages: operand capture; execute (adder, shifter, logic, two 33x17
// partial products); partial product sum, result select and flags.
// A result passes through the capture, execute and result registers in order; one item
// per cycle is sustained while m_axis_tready stays high.
// rst_n is asynchronous and clears the stage valid bits only.
// Each stage holds while the next is full and stalled; tready back-propagates.
`include "integer_alu_with_carry_top_defines.svh"

module integer_alu_with_carry_top
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [iawc_pkg::InDataW-1:0]   s_axis_tdata,  // operand_a, operand_b, carry_in
    input  logic [iawc_pkg::KindW-1:0]     s_axis_tuser,  // kind
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [iawc_pkg::OutDataW-1:0]  m_axis_tdata   // result, carry_out, negative, zero
);

    localparam int W = iawc_pkg::WordW;
    localparam int H = iawc_pkg::HalfW;
    localparam int P = iawc_pkg::PartW;

    logic valid1_reg, valid2_reg, valid3_reg;
    logic valid1_next, valid2_next, valid3_next;
    logic ready1, ready2, ready3;

    iawc_pkg::s1_pay_t s1_reg, s1_next;
    iawc_pkg::s2_pay_t s2_reg, s2_next;

    logic [W-1:0] result_reg, result_next;
    logic         carry_reg, carry_next;
    logic         neg_reg, neg_next;
    logic         zero_reg, zero_next;

    // ready chain
    assign ready3        = !valid3_reg || m_axis_tready;
    assign ready2        = !valid2_reg || ready3;
    assign ready1        = !valid1_reg || ready2;
    assign s_axis_tready = ready1;

    assign valid1_next = ready1 ? s_axis_tvalid : valid1_reg;
    assign valid2_next = ready2 ? valid1_reg    : valid2_reg;
    assign valid3_next = ready3 ? valid2_reg    : valid3_reg;

    // stage 1: capture
    always_comb
    begin
        s1_next.kind = s_axis_tuser;
        s1_next.a    = s_axis_tdata[W-1:0];
        s1_next.b    = s_axis_tdata[2*W-1:W];
        s1_next.cin  = s_axis_tdata[2*W];
        s1_next.a_sx = s_axis_tdata[W-1] &&
                       (s_axis_tuser == iawc_pkg::OP_MULH ||
                        s_axis_tuser == iawc_pkg::OP_MULHSU);
        s1_next.b_sx = s_axis_tdata[2*W-1] && (s_axis_tuser == iawc_pkg::OP_MULH);
    end

    // stage 2: execute
    logic [W:0]          sum;
    logic [W-1:0]        add_x, add_y;
    logic                add_c;
    logic                less_s, less_u;
    logic [4:0]          sh_n;
    logic                sh_fill;
    logic [2*W-1:0]      sh_wide;
    logic [W-1:0]        sh_mask;
    logic                sx_small;
    logic [4:0]          sx_n;
    logic [W-1:0]        sx_keep;
    logic                sx_sign;
    logic [W-1:0]        sx_res;
    logic signed [P-1:0] pp_lo;
    logic signed [P-1:0] pp_hi;
    logic [2*W-1:0]      prod;

    // product split on b; the halves are summed in stage 3
    assign pp_lo = $signed({s1_reg.a_sx, s1_reg.a}) * $signed({1'b0, s1_reg.b[H-1:0]});
    assign pp_hi = $signed({s1_reg.a_sx, s1_reg.a}) * $signed({s1_reg.b_sx, s1_reg.b[W-1:H]});

    always_comb
    begin
        add_x = s1_reg.a;
        add_y = s1_reg.b;
        add_c = 1'b0;
        unique case (iawc_pkg::alu_op_t'(s1_reg.kind))
            iawc_pkg::OP_ADDC:
                add_c = s1_reg.cin;
            iawc_pkg::OP_RSUB:
            begin
                add_x = ~s1_reg.a;
                add_c = 1'b1;
            end
            iawc_pkg::OP_RSUBC:
            begin
                add_x = ~s1_reg.a;
                add_c = s1_reg.cin;
            end
            iawc_pkg::OP_CMP, iawc_pkg::OP_CMPU:
            begin
                add_y = ~s1_reg.b;
                add_c = 1'b1;
            end
            default:
                add_c = 1'b0;
        endcase
        sum = {1'b0, add_x} + {1'b0, add_y} + {{W{1'b0}}, add_c};
    end

    assign less_s = $signed(s1_reg.a) < $signed(s1_reg.b);
    assign less_u = s1_reg.a < s1_reg.b;

    // right shifts: single-bit kinds shift by one
    always_comb
    begin
        if (s1_reg.kind == iawc_pkg::OP_BSRA || s1_reg.kind == iawc_pkg::OP_BSRL)
            sh_n = s1_reg.b[iawc_pkg::ShiftW-1:0];
        else
            sh_n = 5'd1;
        if (s1_reg.kind == iawc_pkg::OP_BSRA || s1_reg.kind == iawc_pkg::OP_SRA)
            sh_fill = s1_reg.a[W-1];
        else if (s1_reg.kind == iawc_pkg::OP_SRC)
            sh_fill = s1_reg.cin;
        else
            sh_fill = 1'b0;
    end

    assign sh_wide = {{W{sh_fill}}, s1_reg.a} >> sh_n;
    assign sh_mask = ~({W{1'b1}} << sh_n);

    // sign extend from width b
    assign sx_small = (s1_reg.b[W-1:iawc_pkg::ShiftW] == '0);
    assign sx_n     = s1_reg.b[iawc_pkg::ShiftW-1:0];
    assign sx_keep  = ~({W{1'b1}} << sx_n);
    assign sx_sign  = s1_reg.a[sx_n - 5'd1];

    always_comb
    begin
        if (!sx_small)
            sx_res = s1_reg.a;
        else if (sx_n == 5'd0)
            sx_res = '0;
        else if (sx_sign)
            sx_res = s1_reg.a | ~sx_keep;
        else
            sx_res = s1_reg.a & sx_keep;
    end

    always_comb
    begin
        s2_next.sel      = iawc_pkg::SEL_MISC;
        s2_next.misc_res = '0;
        s2_next.misc_cy  = 1'b0;
        s2_next.pp_lo    = pp_lo;
        s2_next.pp_hi    = pp_hi;
        unique case (iawc_pkg::alu_op_t'(s1_reg.kind))
            iawc_pkg::OP_ADD, iawc_pkg::OP_ADDC, iawc_pkg::OP_RSUB, iawc_pkg::OP_RSUBC:
            begin
                s2_next.misc_res = sum[W-1:0];
                s2_next.misc_cy  = sum[W];
            end
            iawc_pkg::OP_CMP:
            begin
                s2_next.misc_res = {less_s, sum[W-2:0]};
                s2_next.misc_cy  = sum[W];
            end
            iawc_pkg::OP_CMPU:
            begin
                s2_next.misc_res = {less_u, sum[W-2:0]};
                s2_next.misc_cy  = sum[W];
            end
            iawc_pkg::OP_MUL:
                s2_next.sel = iawc_pkg::SEL_MUL_LO;
            iawc_pkg::OP_MULH, iawc_pkg::OP_MULHU, iawc_pkg::OP_MULHSU:
                s2_next.sel = iawc_pkg::SEL_MUL_HI;
            iawc_pkg::OP_OR:   s2_next.misc_res = s1_reg.a | s1_reg.b;
            iawc_pkg::OP_AND:  s2_next.misc_res = s1_reg.a & s1_reg.b;
            iawc_pkg::OP_XOR:  s2_next.misc_res = s1_reg.a ^ s1_reg.b;
            iawc_pkg::OP_ANDN: s2_next.misc_res = s1_reg.a & ~s1_reg.b;
            iawc_pkg::OP_BSLL:
                s2_next.misc_res = s1_reg.a << s1_reg.b[iawc_pkg::ShiftW-1:0];
            iawc_pkg::OP_BSRA, iawc_pkg::OP_BSRL, iawc_pkg::OP_SRA,
            iawc_pkg::OP_SRC, iawc_pkg::OP_SRL:
            begin
                s2_next.misc_res = sh_wide[W-1:0];
                s2_next.misc_cy  = |(s1_reg.a & sh_mask);
            end
            iawc_pkg::OP_SEXT: s2_next.misc_res = sx_res;
            iawc_pkg::OP_EQ:   s2_next.misc_res = {{(W-1){1'b0}}, s1_reg.a == s1_reg.b};
            iawc_pkg::OP_NE:   s2_next.misc_res = {{(W-1){1'b0}}, s1_reg.a != s1_reg.b};
            iawc_pkg::OP_LT:   s2_next.misc_res = {{(W-1){1'b0}}, less_u};
            iawc_pkg::OP_LE:   s2_next.misc_res = {{(W-1){1'b0}}, !(s1_reg.a > s1_reg.b)};
            iawc_pkg::OP_GT:   s2_next.misc_res = {{(W-1){1'b0}}, s1_reg.a > s1_reg.b};
            iawc_pkg::OP_GE:   s2_next.misc_res = {{(W-1){1'b0}}, !less_u};
            default:
            begin
                s2_next.misc_res = '0;
                s2_next.misc_cy  = 1'b0;
            end
        endcase
    end

    // stage 3: product sum modulo 2^64, select and flags
    assign prod = {{(2*W-P){s2_reg.pp_lo[P-1]}}, s2_reg.pp_lo}
                + {s2_reg.pp_hi[2*W-H-1:0], {H{1'b0}}};

    always_comb
    begin
        unique case (s2_reg.sel)
            iawc_pkg::SEL_MUL_LO:
            begin
                result_next = prod[W-1:0];
                carry_next  = 1'b0;
            end
            iawc_pkg::SEL_MUL_HI:
            begin
                result_next = prod[2*W-1:W];
                carry_next  = 1'b0;
            end
            default:
            begin
                result_next = s2_reg.misc_res;
                carry_next  = s2_reg.misc_cy;
            end
        endcase
        neg_next  = result_next[W-1];
        zero_next = (result_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
        end
        else
        begin
            valid1_reg <= valid1_next;
            valid2_reg <= valid2_next;
            valid3_reg <= valid3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1 && s_axis_tvalid)
            s1_reg <= s1_next;
        if (ready2 && valid1_reg)
            s2_reg <= s2_next;
        if (ready3 && valid2_reg)
        begin
            result_reg <= result_next;
            carry_reg  <= carry_next;
            neg_reg    <= neg_next;
            zero_reg   <= zero_next;
        end
    end

    assign m_axis_tvalid = valid3_reg;
    assign m_axis_tdata  = {5'b0, zero_reg, neg_reg, carry_reg, result_reg};

    `IAWC_ASSERT_NEXT(a_s2_hold, clk, rst_n, valid2_reg && !ready3, valid2_reg)
    `IAWC_ASSERT_IMPLY(a_empty_ready, clk, rst_n, !valid1_reg, s_axis_tready)
    `IAWC_ASSERT_IMPLY(a_zero_flag, clk, rst_n, valid3_reg, zero_reg == (result_reg == '0))
    `IAWC_ASSERT_IMPLY(a_neg_flag, clk, rst_n, valid3_reg, neg_reg == result_reg[W-1])
    `IAWC_ASSERT_NEXT(a_mul_no_carry, clk, rst_n, valid2_reg && ready3 && s2_reg.sel != iawc_pkg::SEL_MISC, !carry_reg)

endmodule
